### rtl/cbs_pkg.sv
// ----------------------------------------------------------------------------
// cbs_pkg
// Shared types and constants for the charlieplex bit-plane scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package cbs_pkg;

  localparam int PIN_W     = 4;   // pin index width
  localparam int PLANE_W   = 4;   // bit plane width, planes 0..8
  localparam int LEVEL_W   = 8;   // brightness level width
  localparam int INDEX_W   = 7;   // led_index field width
  localparam int LAST_PLANE = 8;  // dark pass, no level bit behind it

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_TICK  = 1'b1
  } opcode_t;

  // Scan position of the slot being read.
  typedef struct packed {
    logic [PIN_W-1:0]   anode;
    logic [PIN_W-1:0]   cathode;
    logic [PLANE_W-1:0] plane;
    logic               pass_end;
  } slot_info_t;

endpackage

`default_nettype wire

### rtl/charlieplex_bitplane_scanner.sv
// ----------------------------------------------------------------------------
// charlieplex_bitplane_scanner
// Bit-plane scanner for a charlieplexed LED ring with a per-LED level store.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Beat content
// -------  ---  --------------------------------------------------------------
// s_*      in   tuser = opcode (write level / tick), tdata = led_index, level
// m_*      out  one beat per tick: anode, cathode, lit, plane; tlast = pass end
//
// One input beat per cycle while s_tready is high, writes and ticks alike. A
// tick's result passes through the frame store read port and then the output
// register before it shows on m_*. Reset clears the per-LED valid bits, so
// there is no clearing pass; unwritten LEDs read as level zero. A full output
// register holds while m_tready is low, the read stage holds behind it, and
// s_tready drops only while both stages hold a beat and m_tready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module charlieplex_bitplane_scanner #(
  parameter int NUM_PINS = 10
) (
  input  wire         clk,
  input  wire         rst,
  // input beats
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [15:0] s_tdata,   // [6:0] led_index, [14:7] level, [15] zero
  input  wire         s_tuser,   // [0] opcode
  // result beats
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [15:0] m_tdata,   // [3:0] anode_pin, [7:4] cathode_pin, [8] lit,
                                 // [12:9] plane, [15:13] zero
  output logic        m_tlast    // pass_end
);

  localparam int NUM_LEDS = NUM_PINS * (NUM_PINS - 1);
  localparam int SLOT_W   = $clog2(NUM_LEDS);
  localparam int CMP_W    = (SLOT_W > cbs_pkg::INDEX_W) ? SLOT_W : cbs_pkg::INDEX_W;
  localparam logic [cbs_pkg::PLANE_W-1:0] DARK_PLANE =
    cbs_pkg::PLANE_W'(cbs_pkg::LAST_PLANE);

  // input beat decode
  logic                          in_accept;
  cbs_pkg::opcode_t              opcode;
  logic [cbs_pkg::INDEX_W-1:0]   led_index;
  logic [cbs_pkg::LEVEL_W-1:0]   level;
  logic [CMP_W-1:0]              index_ext;
  logic                          wr_en;
  logic                          tick;
  logic [SLOT_W-1:0]             wr_addr;

  assign in_accept = s_tvalid && s_tready;
  assign opcode    = cbs_pkg::opcode_t'(s_tuser);
  assign led_index = s_tdata[6:0];
  assign level     = s_tdata[14:7];
  assign index_ext = CMP_W'(led_index);
  assign wr_addr   = index_ext[SLOT_W-1:0];
  // out-of-range writes are dropped
  assign wr_en     = in_accept && (opcode == cbs_pkg::OP_WRITE) &&
                     (index_ext < CMP_W'(NUM_LEDS));
  assign tick      = in_accept && (opcode == cbs_pkg::OP_TICK);

  // scan sequencer
  logic [SLOT_W-1:0]   rd_addr;
  cbs_pkg::slot_info_t cur_info;

  cbs_scan_ctrl #(
    .NUM_PINS (NUM_PINS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .advance   (tick),
    .slot_addr (rd_addr),
    .info      (cur_info)
  );

  // frame store; read data holds while no tick is taken
  logic [cbs_pkg::LEVEL_W-1:0] rd_level;

  cbs_ram #(
    .WIDTH (cbs_pkg::LEVEL_W),
    .DEPTH (NUM_LEDS)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (level),
    .re    (tick),
    .raddr (rd_addr),
    .rdata (rd_level)
  );

  // per-LED written flags stand in for clearing the store at reset
  logic [NUM_LEDS-1:0] written;

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  // read stage
  logic                s1_valid;
  cbs_pkg::slot_info_t s1_info;
  logic                s1_written;
  logic                out_free;
  logic                s1_move;

  assign out_free = !m_tvalid || m_tready;
  assign s1_move  = s1_valid && out_free;
  assign s_tready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= tick;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      s1_info    <= cur_info;
      s1_written <= written[rd_addr];
    end
  end

  // lit: selected plane bit, dark on the ninth pass
  logic lit_next;

  always_comb begin
    if (s1_written && (s1_info.plane != DARK_PLANE) && (s1_info.plane < DARK_PLANE)) begin
      lit_next = rd_level[s1_info.plane[2:0]];
    end else begin
      lit_next = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      m_tdata <= {3'b000, s1_info.plane, lit_next, s1_info.cathode, s1_info.anode};
      m_tlast <= s1_info.pass_end;
    end
  end

endmodule

`default_nettype wire

### rtl/cbs_ram.sv
// ----------------------------------------------------------------------------
// cbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 90
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire [$clog2(DEPTH)-1:0]   waddr,
  input  wire [WIDTH-1:0]           wdata,
  input  wire                       re,
  input  wire [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/cbs_scan_ctrl.sv
// ----------------------------------------------------------------------------
// cbs_scan_ctrl
// Slot sequencer: anode from top pin down, cathodes ascending, planes 0..8.
// ----------------------------------------------------------------------------
`default_nettype none

module cbs_scan_ctrl #(
  parameter int NUM_PINS = 10
) (
  input  wire                                        clk,
  input  wire                                        rst,
  input  wire                                        advance,
  output logic [$clog2(NUM_PINS*(NUM_PINS-1))-1:0]   slot_addr,
  output cbs_pkg::slot_info_t                        info
);

  localparam int NUM_LEDS = NUM_PINS * (NUM_PINS - 1);
  localparam int SLOT_W   = $clog2(NUM_LEDS);
  localparam logic [cbs_pkg::PIN_W-1:0] TOP_PIN = cbs_pkg::PIN_W'(NUM_PINS - 1);
  localparam logic [cbs_pkg::PIN_W-1:0] LAST_POS = cbs_pkg::PIN_W'(NUM_PINS - 2);
  localparam logic [cbs_pkg::PLANE_W-1:0] LAST_PLANE_C =
    cbs_pkg::PLANE_W'(cbs_pkg::LAST_PLANE);

  logic [SLOT_W-1:0]           slot;
  logic [cbs_pkg::PIN_W-1:0]   anode;
  logic [cbs_pkg::PIN_W-1:0]   pos;
  logic [cbs_pkg::PLANE_W-1:0] plane;
  logic                        group_end;
  logic                        last;

  assign group_end = (pos == LAST_POS);
  assign last      = group_end && (anode == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot  <= '0;
      anode <= TOP_PIN;
      pos   <= '0;
      plane <= '0;
    end else if (advance) begin
      if (last) begin
        slot  <= '0;
        anode <= TOP_PIN;
        pos   <= '0;
        plane <= (plane == LAST_PLANE_C) ? '0 : plane + 1'b1;
      end else if (group_end) begin
        slot  <= slot + 1'b1;
        anode <= anode - 1'b1;
        pos   <= '0;
      end else begin
        slot  <= slot + 1'b1;
        pos   <= pos + 1'b1;
      end
    end
  end

  // Cathode skips over the anode pin.
  always_comb begin
    info.anode    = anode;
    info.cathode  = (pos < anode) ? pos : pos + 1'b1;
    info.plane    = plane;
    info.pass_end = last;
  end

  assign slot_addr = slot;

endmodule

`default_nettype wire

### rtl/cbs_checker.sv
// ----------------------------------------------------------------------------
// cbs_checker
// Port-level checks on the scanner's result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module cbs_checker #(
  parameter int NUM_PINS = 10
) (
  input wire        clk,
  input wire        rst,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [15:0] m_tdata,
  input wire        m_tlast
);

  localparam logic [3:0] TOP_PIN = 4'(NUM_PINS - 1);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // anode and cathode never share a pin
  a_pins: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[3:0] != m_tdata[7:4]))
    else $error("anode equals cathode");

  // ninth pass is dark
  a_dark: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[12:9] == 4'd8) |-> !m_tdata[8])
    else $error("lit on dark plane");

  // pass ends on anode 0, top cathode
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> (m_tdata[3:0] == 4'd0) && (m_tdata[7:4] == TOP_PIN))
    else $error("pass end at wrong slot");

  // nothing comes out in the cycle after reset
  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind charlieplex_bitplane_scanner cbs_checker #(
  .NUM_PINS (NUM_PINS)
) u_cbs_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire
